@@ sv/assert_macros.svh @@
// Assertion helpers, sampled on the block clock, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define SEM_ASSERT_NEXT(lbl, pre, post, msg) \
  `SEM_ASSERT(lbl, (pre) |=> (post), msg)

`endif

@@ sv/sem_pkg.sv @@
package sem_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = COL_W + 1;
  localparam int HGT_W     = 12;
  localparam int ROW_W     = HGT_W + 1;
  localparam int CFGW_W    = 11;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int GRAD_W    = 11;
  localparam int SUM_W     = 21;
  localparam int CLAMP_LIM = 65280;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_PUSH,
    ST_GRAD,
    ST_SUM,
    ST_ROOT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic       capture;
    logic       restart;
    logic       rd;
    logic       push;
    logic       grad;
    logic       sum;
    logic       root_step;
    logic [2:0] bit_idx;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic frame_done;
    logic drained;
    logic emit_ok;
    logic out_busy;
  } status_t;

endpackage

@@ sv/sem_ram.sv @@
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/sem_ctrl.sv @@
module sem_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_kind_i,
  output logic             in_ready_o,
  input  sem_pkg::status_t status_i,
  output sem_pkg::cmd_t    cmd_o
);
  import sem_pkg::*;

  state_e     state_q, state_d;
  logic       emit_q, emit_d;
  logic       double_q, double_d;
  logic [2:0] bit_q, bit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      emit_q   <= 1'b0;
      double_q <= 1'b0;
      bit_q    <= '0;
    end else begin
      state_q  <= state_d;
      emit_q   <= emit_d;
      double_q <= double_d;
      bit_q    <= bit_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    emit_d     = emit_q;
    double_d   = double_q;
    bit_d      = bit_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.bit_idx = bit_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (in_kind_i == KIND_PIXEL) begin
            cmd_o.restart = status_i.frame_done;
            emit_d   = !status_i.frame_done && status_i.emit_ok;
            double_d = 1'b0;
            state_d  = ST_READ;
          end else if (status_i.frame_done && !status_i.drained) begin
            emit_d   = 1'b1;
            double_d = !status_i.emit_ok;
            state_d  = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_PUSH;
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        if (double_q) begin
          double_d = 1'b0;
          state_d  = ST_READ;
        end else if (emit_q) begin
          state_d = ST_GRAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_GRAD: begin
        cmd_o.grad = 1'b1;
        state_d    = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        bit_d     = 3'd7;
        state_d   = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        bit_d = bit_q - 3'd1;
        if (bit_q == 3'd0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/sem_datapath.sv @@
module sem_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sem_pkg::cmd_t              cmd_i,
  output sem_pkg::status_t           status_o,
  input  logic                       in_kind_i,
  input  logic [sem_pkg::PIX_W-1:0]  in_pix_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [sem_pkg::HGT_W-1:0]  cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sem_pkg::PIX_W-1:0]  out_pix_o,
  output logic                       out_last_o
);
  import sem_pkg::*;

  logic [CFGW_W-1:0] width_q;
  logic [HGT_W-1:0]  height_q;
  logic [WID_W-1:0]  w_eff;
  logic [HGT_W-1:0]  h_eff;

  logic [COL_W-1:0]  in_col_q, out_col_q;
  logic [ROW_W-1:0]  in_row_q;
  logic [HGT_W-1:0]  out_row_q;
  logic [PIX_W-1:0]  pix_q;
  logic [PIX_W-1:0]  win_q [3][3];
  logic [PIX_W-1:0]  top_rd, mid_rd;

  logic signed [GRAD_W-1:0] gx_q [3];
  logic signed [GRAD_W-1:0] gy_q [3];
  logic [SUM_W-1:0]         s_q [3];
  logic [CH_W-1:0]          r_q [3];
  logic                     last_q;

  logic              out_valid_q, out_last_q;
  logic [PIX_W-1:0]  out_pix_q;

  // effective frame size
  always_comb begin
    if (width_q == '0) begin
      w_eff = WID_W'(1);
    end else if ({1'b0, width_q} > (CFGW_W + 1)'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(width_q);
    end
    h_eff = (height_q == '0) ? HGT_W'(1) : height_q;
  end

  assign status_o.frame_done = in_row_q >= ROW_W'(h_eff);
  assign status_o.drained    = out_row_q >= h_eff;
  assign status_o.emit_ok    = (in_row_q > ROW_W'(1)) ||
                               ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (in_col_q),
    .wdata_i (mid_rd),
    .re_i    (cmd_i.rd),
    .raddr_i (in_col_q),
    .rdata_o (top_rd)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (in_col_q),
    .wdata_i (pix_q),
    .re_i    (cmd_i.rd),
    .raddr_i (in_col_q),
    .rdata_o (mid_rd)
  );

  logic in_col_wrap, out_col_wrap;
  assign in_col_wrap  = (WID_W'(in_col_q) + WID_W'(1)) >= w_eff;
  assign out_col_wrap = (WID_W'(out_col_q) + WID_W'(1)) >= w_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= CFGW_W'(640);
      height_q  <= HGT_W'(480);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FRAME_WIDTH) begin
          width_q <= cfg_data_i[CFGW_W-1:0];
        end else begin
          height_q <= cfg_data_i;
        end
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else begin
        if (cmd_i.restart) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end
        if (cmd_i.push) begin
          for (int i = 0; i < 3; i++) begin
            win_q[i][0] <= win_q[i][1];
            win_q[i][1] <= win_q[i][2];
          end
          win_q[0][2] <= top_rd;
          win_q[1][2] <= mid_rd;
          win_q[2][2] <= pix_q;
          if (in_col_wrap) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + ROW_W'(1);
          end else begin
            in_col_q <= in_col_q + COL_W'(1);
          end
        end
        if (cmd_i.grad) begin
          if (out_col_wrap) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + HGT_W'(1);
          end else begin
            out_col_q <= out_col_q + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q <= (in_kind_i == KIND_DRAIN) ? '0 : in_pix_i;
    end
  end

  // border masks for the current result position
  logic row_top_off, row_bot_off, col_l_off, col_r_off;
  assign row_top_off = out_row_q == '0;
  assign row_bot_off = (ROW_W'(out_row_q) + ROW_W'(1)) >= ROW_W'(h_eff);
  assign col_l_off   = out_col_q == '0;
  assign col_r_off   = out_col_wrap;

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    localparam int SH = 16 - 8 * ch;
    logic [GRAD_W-1:0] p [3][3];
    logic [GRAD_W-1:0] right, left, bot, top;
    logic [CH_W-1:0]   t;
    logic [2*CH_W-1:0] tsq, rsq;
    logic [SUM_W-1:0]  rem;
    logic [CH_W-1:0]   res;
    logic signed [2*GRAD_W-1:0] gx2, gy2;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if ((i == 0 && row_top_off) || (i == 2 && row_bot_off) ||
              (j == 0 && col_l_off) || (j == 2 && col_r_off)) begin
            p[i][j] = '0;
          end else begin
            p[i][j] = GRAD_W'(win_q[i][j][SH +: CH_W]);
          end
        end
      end
      right = p[0][2] + (p[1][2] << 1) + p[2][2];
      left  = p[0][0] + (p[1][0] << 1) + p[2][0];
      bot   = p[2][0] + (p[2][1] << 1) + p[2][2];
      top   = p[0][0] + (p[0][1] << 1) + p[0][2];
      // full-width signed squares
      gx2   = gx_q[ch] * gx_q[ch];
      gy2   = gy_q[ch] * gy_q[ch];
      t     = r_q[ch] | (CH_W'(1) << cmd_i.bit_idx);
      tsq   = t * t;
      rsq   = r_q[ch] * r_q[ch];
      rem   = s_q[ch] - SUM_W'(rsq);
      if (s_q[ch] > SUM_W'(CLAMP_LIM)) begin
        res = '1;
      end else if (rem > SUM_W'(r_q[ch])) begin
        res = r_q[ch] + CH_W'(1);
      end else begin
        res = r_q[ch];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.grad) begin
        gx_q[ch] <= $signed(right - left);
        gy_q[ch] <= $signed(bot - top);
      end
      if (cmd_i.sum) begin
        s_q[ch] <= SUM_W'($unsigned(gx2)) + SUM_W'($unsigned(gy2));
        r_q[ch] <= '0;
      end
      if (cmd_i.root_step && (SUM_W'(tsq) <= s_q[ch])) begin
        r_q[ch] <= t;
      end
      if (cmd_i.fin) begin
        out_pix_q[SH +: CH_W] <= res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      last_q <= ((ROW_W'(out_row_q) + ROW_W'(1)) == ROW_W'(h_eff)) &&
                ((WID_W'(out_col_q) + WID_W'(1)) == w_eff);
    end
    if (cmd_i.fin) begin
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;
  assign out_last_o  = out_last_q;

endmodule

@@ sv/sobel_edge_magnitude_rgb.sv @@
// A pixel that releases a result passes read, push, gradient, square sum, eight root
// steps and rounding before it shows the result; a drain that pushes two columns reads
// and pushes twice first. Pixels without a result only read and push; ignored drains
// leave the block idle. A new item is taken only once the last one is done, set by the
// line store read/write sequence and the bit-per-cycle square root, later while the
// result port stalls. Reset is asynchronous, active low: counters, window and output
// valid clear; line stores are not cleared.
module sobel_edge_magnitude_rgb (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,  // red_in, green_in, blue_in
  input  logic                      s_axis_tuser,  // kind
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,  // red_edge, green_edge, blue_edge
  output logic                      m_axis_tlast,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [11:0]               cfg_data_i
);
  import sem_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [PIX_W-1:0] in_pix, out_pix;

  // internal packing is red high, blue low
  assign in_pix = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
  assign m_axis_tdata = {out_pix[7:0], out_pix[15:8], out_pix[23:16]};
  assign cfg_ready_o = 1'b1;

  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sem_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_kind_i   (s_axis_tuser),
    .in_pix_i    (in_pix),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pix_o   (out_pix),
    .out_last_o  (m_axis_tlast)
  );

endmodule

@@ sv/sem_checker.sv @@
`include "assert_macros.svh"

module sem_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  `SEM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed under stall")
  `SEM_ASSERT_NEXT(a_pixel_busy, s_axis_tvalid && s_axis_tready && !s_axis_tuser, !s_axis_tready, "input taken during line store access")
  `SEM_ASSERT_NEXT(a_no_early_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result appeared right after a transaction")
  `SEM_ASSERT(a_result_idle, $rose(m_axis_tvalid) |-> s_axis_tready, "result loaded while busy")

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import sem_pkg::*;

  localparam int  LIMIT_CYCLES = 3000000;
  localparam int  MAX_GAP      = 8;

  typedef struct {
    logic        kind;
    logic [23:0] rgb;  // red 23..16, green 15..8, blue 7..0
  } pix_item_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } edge_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [11:0] cfg_data_i;

  sobel_edge_magnitude_rgb dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  pix_item_t pix_q[$];
  edge_res_t edge_q[$];
  int        errors;
  int        cycles;
  int        n_pixels, n_drains, n_checked, n_writes;
  logic      src_idle_on, snk_idle_on;

  // ---------------- Sobel predictor state ----------------
  logic [10:0] sh_width;
  logic [11:0] sh_height;
  logic [23:0] sh_upper  [MAX_WIDTH];
  logic [23:0] sh_middle [MAX_WIDTH];
  logic [23:0] sh_win    [3][3];
  int          in_col, in_row, out_col, out_row;

  function automatic int eff_w();
    if (sh_width < 1) return 1;
    if (sh_width > MAX_WIDTH) return MAX_WIDTH;
    return int'(sh_width);
  endfunction

  function automatic int eff_h();
    return (sh_height < 1) ? 1 : int'(sh_height);
  endfunction

  task automatic restart_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endtask

  task automatic shift_in(input logic [23:0] pix);
    logic [23:0] top, mid;
    top = sh_upper[in_col];
    mid = sh_middle[in_col];
    sh_upper[in_col]  = mid;
    sh_middle[in_col] = pix;
    for (int i = 0; i < 3; i++) begin
      sh_win[i][0] = sh_win[i][1];
      sh_win[i][1] = sh_win[i][2];
    end
    sh_win[0][2] = top;
    sh_win[1][2] = mid;
    sh_win[2][2] = pix;
    in_col++;
    if (in_col >= eff_w()) begin
      in_col = 0;
      in_row++;
    end
  endtask

  function automatic logic [7:0] rounded_mag(input int gx, input int gy);
    int unsigned s, r, t;
    s = gx * gx + gy * gy;
    r = 0;
    if (s > CLAMP_LIM) return 8'd255;
    for (int b = 7; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= s) r = t;
    end
    if (s - r * r > r) r++;
    return r[7:0];
  endfunction

  task automatic emit_edge();
    edge_res_t res;
    int        p[3][3];
    int        gx, gy;
    logic [7:0] m[3];
    logic      off;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          off = (i == 0 && out_row == 0) || (i == 2 && out_row + 1 >= eff_h()) ||
                (j == 0 && out_col == 0) || (j == 2 && out_col + 1 >= eff_w());
          p[i][j] = off ? 0 : int'((sh_win[i][j] >> (16 - 8 * ch)) & 24'hFF);
        end
      gx = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
      gy = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
      m[ch] = rounded_mag(gx, gy);
    end
    res.red       = m[0];
    res.green     = m[1];
    res.blue      = m[2];
    res.frame_end = (out_row + 1 == eff_h() && out_col + 1 == eff_w());
    edge_q.push_back(res);
    out_col++;
    if (out_col >= eff_w()) begin
      out_col = 0;
      out_row++;
    end
  endtask

  task automatic predict_edges(input logic kind, input logic [23:0] pix);
    int pos;
    if (kind == KIND_PIXEL) begin
      n_pixels++;
      if (in_row >= eff_h()) restart_frame();
      pos = in_row * eff_w() + in_col;
      shift_in(pix);
      if (pos >= eff_w() + 1) emit_edge();
    end else begin
      n_drains++;
      if (in_row < eff_h() || out_row >= eff_h()) return;
      pos = in_row * eff_w() + in_col;
      shift_in(24'h0);
      if (pos < eff_w() + 1) shift_in(24'h0);
      emit_edge();
    end
  endtask

  task automatic report(input string what);
    errors++;
    $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  // ---------------- pixel source ----------------
  int src_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    pix_item_t it;
    logic      fire;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= KIND_PIXEL;
      src_gap = 0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire)
        predict_edges(s_axis_tuser,
                      {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]});
      if (fire || !s_axis_tvalid) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pix_q.size() > 0) begin
          it = pix_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= it.kind;
          s_axis_tdata  <= {it.rgb[7:0], it.rgb[15:8], it.rgb[23:16]};
          if ($urandom_range(0, 63) == 0) src_idle_on = ~src_idle_on;
          src_gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result sink ----------------
  int snk_stall;
  always @(posedge clk_i or negedge rst_ni) begin
    edge_res_t want;
    logic      fire;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_stall = 0;
    end else begin
      fire = m_axis_tvalid && m_axis_tready;
      if (fire) begin
        n_checked++;
        if (edge_q.size() == 0) begin
          report($sformatf("unexpected result data=%h last=%b", m_axis_tdata, m_axis_tlast));
        end else begin
          want = edge_q.pop_front();
          if (m_axis_tdata[7:0] !== want.red)
            report($sformatf("red_edge got %0d want %0d", m_axis_tdata[7:0], want.red));
          if (m_axis_tdata[15:8] !== want.green)
            report($sformatf("green_edge got %0d want %0d", m_axis_tdata[15:8], want.green));
          if (m_axis_tdata[23:16] !== want.blue)
            report($sformatf("blue_edge got %0d want %0d", m_axis_tdata[23:16], want.blue));
          if (m_axis_tlast !== want.frame_end)
            report($sformatf("frame_end got %b want %b", m_axis_tlast, want.frame_end));
        end
        if ($urandom_range(0, 63) == 0) snk_idle_on = ~snk_idle_on;
        snk_stall = snk_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (fire || !m_axis_tready) begin
        if (snk_stall > 0) begin
          snk_stall--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_item(input logic kind);
    pix_item_t it;
    it.kind = kind;
    it.rgb  = {rand_chan(), rand_chan(), rand_chan()};
    pix_q.push_back(it);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pix_q.size() != 0 || s_axis_tvalid || edge_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [11:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    n_writes++;
    if (idx == CFG_FRAME_WIDTH) sh_width = val[10:0];
    else sh_height = val;
    restart_frame();
  endtask

  // one frame of pixels, optionally with a stray drain, then n_drain drains
  task automatic queue_frame(input int n_drain, input logic stray);
    int total, at;
    total = eff_w() * eff_h();
    at = stray ? $urandom_range(0, total - 1) : -1;
    for (int k = 0; k < total; k++) begin
      if (k == at) queue_item(KIND_DRAIN);
      queue_item(KIND_PIXEL);
    end
    repeat (n_drain) queue_item(KIND_DRAIN);
  endtask

  task automatic phase(input logic [11:0] w, input logic [11:0] h, input int frames);
    int full;
    wait_idle();
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_FRAME_WIDTH, w);
      write_reg(CFG_FRAME_HEIGHT, h);
    end else begin
      write_reg(CFG_FRAME_HEIGHT, h);
      write_reg(CFG_FRAME_WIDTH, w);
    end
    for (int f = 0; f < frames; f++) begin
      full = eff_w() + 1;
      if (f + 1 < frames && $urandom_range(0, 1))
        queue_frame($urandom_range(0, full), $urandom_range(0, 5) == 0);
      else
        queue_frame(full + $urandom_range(0, 2), $urandom_range(0, 5) == 0);
    end
  endtask

  initial begin
    int queued;
    logic [11:0] w, h;
    errors = 0; cycles = 0;
    n_pixels = 0; n_drains = 0; n_checked = 0; n_writes = 0;
    src_idle_on = 1'b1; snk_idle_on = 1'b1;
    cfg_valid_i = 1'b0; cfg_index_i = CFG_FRAME_WIDTH; cfg_data_i = '0;
    sh_width = 11'd640; sh_height = 12'd480;
    foreach (sh_upper[i]) begin
      sh_upper[i] = '0;
      sh_middle[i] = '0;
    end
    foreach (sh_win[i, j]) sh_win[i][j] = '0;
    restart_frame();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: drain before any frame data, then a 3x3 frame and six drains
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 12'd3);
    write_reg(CFG_FRAME_HEIGHT, 12'd3);
    queue_item(KIND_DRAIN);
    for (int k = 0; k < 9; k++) begin
      pix_item_t it;
      it.kind = KIND_PIXEL;
      it.rgb  = (k % 2) ? 24'hFFFFFF : 24'h000000;
      if (k == 4) it.rgb = 24'hFF00FF;
      pix_q.push_back(it);
    end
    repeat (6) queue_item(KIND_DRAIN);
    phase(12'd4, 12'd1, 1);     // single row
    phase(12'd0, 12'd0, 1);     // zero acts as one
    phase(12'd1, 12'd5, 2);

    // width above the line store clamps to it; one row, then 50 drains
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 12'd2047);
    write_reg(CFG_FRAME_HEIGHT, 12'd1);
    queue_frame(50, 1'b0);

    // tallest frame, one pixel wide, first rows only
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 12'd1);
    write_reg(CFG_FRAME_HEIGHT, 12'd4095);
    repeat (300) queue_item(KIND_PIXEL);

    queued = n_pixels + n_drains + pix_q.size();
    while (queued < 2000) begin
      w = 12'($urandom_range(1, 8));
      h = 12'($urandom_range(1, 6));
      if ($urandom_range(0, 15) == 0) w = 12'd0;
      if ($urandom_range(0, 15) == 0) h = 12'd0;
      phase(w, h, $urandom_range(1, 3));
      queued += pix_q.size();
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    $display("covered %0d pixels, %0d drains, %0d register writes", n_pixels, n_drains,
             n_writes);
    $display("%0d edge results compared, %0d errors", n_checked, errors);
    if (errors == 0 && edge_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/sem_pkg.sv
sv/sem_ram.sv
sv/sem_ctrl.sv
sv/sem_datapath.sv
sv/sobel_edge_magnitude_rgb.sv
sv/sem_checker.sv
tb/tb.sv
